// ----- rtl/core/mtss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtss_pkg: shared types and codes of the span shader
// Operation codes, register indexes, queue entry and configuration bundles.
// ----------------------------------------------------------------------------
package mtss_pkg;

   typedef enum logic [2:0] {
      OP_LOAD_TEXEL = 3'd0,
      OP_LOAD_SHADE = 3'd1,
      OP_LOAD_BLEND = 3'd2,
      OP_START_SPAN = 3'd3,
      OP_PIXEL      = 3'd4
   } op_code_type;

   typedef enum logic [1:0] {
      CSR_U_SHIFT    = 2'd0,
      CSR_V_BITS     = 2'd1,
      CSR_BLEND_MODE = 2'd2,
      CSR_SWAP_BLEND = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_LOAD_TEXEL = 3'd0,
      KIND_LOAD_SHADE = 3'd1,
      KIND_LOAD_BLEND = 3'd2,
      KIND_PIXEL      = 3'd3,
      KIND_EXHAUSTED  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic [4:0] u_shift;
      logic [4:0] v_bits;
      logic       blend_mode;
      logic       swap_blend;
   } cfg_type;

   localparam logic [7:0] TRANSPARENT_TEXEL = 8'hff;
   localparam logic [4:0] U_SHIFT_RESET     = 5'd26;
   localparam logic [4:0] V_BITS_RESET      = 5'd6;
   localparam int         REQ_DATA_BITS     = 168;

endpackage
`default_nettype wire

// ----- rtl/core/mtss_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtss_front: request decode and span stepping
// Accepts request beats, steps the U/V accumulators and span count, builds
// the texel index and pushes one classified entry per beat that needs work.
// ----------------------------------------------------------------------------
module mtss_front #(
   parameter int TEX_BITS   = 16,
   parameter int SPAN_BITS  = 12,
   parameter int QADDR_BITS = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [2:0]                        req_tuser,
   input  wire  [mtss_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  mtss_pkg::cfg_type                 cfg,
   input  wire                               q_full,
   output logic                              push,
   output mtss_pkg::entry_type               push_entry,
   output logic [QADDR_BITS-1:0]             push_addr
);

   logic              accept;
   logic [15:0]       table_address;
   logic [7:0]        byte_value;
   logic [31:0]       u_start, v_start, u_increment, v_increment;
   logic [11:0]       span_length;
   logic [SPAN_BITS-1:0] span_len_masked;
   logic [31:0]       u_acc_ff, u_acc_in, v_acc_ff, v_acc_in;
   logic [31:0]       u_step_ff, u_step_in, v_step_ff, v_step_in;
   logic [SPAN_BITS:0] left_ff, left_in;
   logic [31:0]       u_shifted, u_part, v_part;
   logic [TEX_BITS-1:0] texel_index;

   assign req_tready    = !q_full;
   assign accept        = req_tvalid && !q_full;
   assign table_address = req_tdata[15:0];
   assign byte_value    = req_tdata[23:16];
   assign u_start       = req_tdata[55:24];
   assign v_start       = req_tdata[87:56];
   assign u_increment   = req_tdata[119:88];
   assign v_increment   = req_tdata[151:120];
   assign span_length   = req_tdata[163:152];
   assign span_len_masked = SPAN_BITS'(span_length);

   assign u_shifted   = u_acc_ff >> cfg.u_shift;
   assign u_part      = u_shifted << cfg.v_bits;
   assign v_part      = (v_acc_ff >> 1) >> (5'd31 - cfg.v_bits);
   assign texel_index = TEX_BITS'(u_part | v_part);

   always_comb begin
      push            = 1'b0;
      push_entry.kind = mtss_pkg::KIND_PIXEL;
      push_entry.data = byte_value;
      push_entry.last = 1'b0;
      push_addr       = QADDR_BITS'(table_address);
      u_acc_in        = u_acc_ff;
      v_acc_in        = v_acc_ff;
      u_step_in       = u_step_ff;
      v_step_in       = v_step_ff;
      left_in         = left_ff;
      case (mtss_pkg::op_code_type'(req_tuser))
         mtss_pkg::OP_LOAD_TEXEL: begin
            push            = accept;
            push_entry.kind = mtss_pkg::KIND_LOAD_TEXEL;
         end
         mtss_pkg::OP_LOAD_SHADE: begin
            push            = accept;
            push_entry.kind = mtss_pkg::KIND_LOAD_SHADE;
         end
         mtss_pkg::OP_LOAD_BLEND: begin
            push            = accept;
            push_entry.kind = mtss_pkg::KIND_LOAD_BLEND;
         end
         mtss_pkg::OP_START_SPAN: begin
            if (accept) begin
               u_acc_in  = u_start;
               v_acc_in  = v_start;
               u_step_in = u_increment;
               v_step_in = v_increment;
               left_in   = {1'b0, span_len_masked} + 1'b1;
            end
         end
         mtss_pkg::OP_PIXEL: begin
            push = accept;
            if (left_ff == '0) begin
               push_entry.kind = mtss_pkg::KIND_EXHAUSTED;
            end else begin
               push_entry.kind = mtss_pkg::KIND_PIXEL;
               push_entry.last = (left_ff == (SPAN_BITS+1)'(1));
               push_addr       = QADDR_BITS'(texel_index);
               if (accept) begin
                  u_acc_in = u_acc_ff + u_step_ff;
                  v_acc_in = v_acc_ff + v_step_ff;
                  left_in  = left_ff - 1'b1;
               end
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_acc_ff  <= '0;
         v_acc_ff  <= '0;
         u_step_ff <= '0;
         v_step_ff <= '0;
         left_ff   <= '0;
      end else begin
         u_acc_ff  <= u_acc_in;
         v_acc_ff  <= v_acc_in;
         u_step_ff <= u_step_in;
         v_step_ff <= v_step_in;
         left_ff   <= left_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/mtss_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtss_queue: four-entry queue between front and back
// Holds classified entries so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mtss_queue #(
   parameter int QADDR_BITS = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  mtss_pkg::entry_type    push_entry,
   input  wire  [QADDR_BITS-1:0]  push_addr,
   output logic                   full,
   input  wire                    pop,
   output logic                   head_valid,
   output mtss_pkg::entry_type    head_entry,
   output logic [QADDR_BITS-1:0]  head_addr
);

   localparam int DEPTH = 4;

   mtss_pkg::entry_type   entry_ff [DEPTH];
   logic [QADDR_BITS-1:0] addr_ff  [DEPTH];
   logic [1:0]            wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0]            count_ff, count_in;
   logic                  do_pop;

   assign full       = (count_ff == 3'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign head_addr  = addr_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + 3'(push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
         addr_ff[wr_ptr_ff]  <= push_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/mtss_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtss_back: table pipeline and result register
// Texture, shade and blend stores each sit in a stage of their own; loads
// write in the stage that owns their store, pixels read through all three.
// ----------------------------------------------------------------------------
module mtss_back #(
   parameter int TEX_BITS   = 16,
   parameter int QADDR_BITS = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  mtss_pkg::cfg_type      cfg,
   input  wire                    head_valid,
   input  mtss_pkg::entry_type    head_entry,
   input  wire  [QADDR_BITS-1:0]  head_addr,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   logic [7:0] tex_mem   [2**TEX_BITS];
   logic [7:0] shade_mem [256];
   logic [7:0] blend_mem [65536];

   logic                advance;
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   mtss_pkg::entry_type s1_entry_ff, s2_entry_ff, s3_entry_ff;
   logic [15:0]         s1_addr_ff, s2_addr_ff;
   logic [7:0]          s1_texel_ff;
   logic [7:0]          s2_shaded_ff, s3_shaded_ff;
   logic                s2_clear_ff, s3_clear_ff;
   logic [7:0]          s3_blend_ff;
   logic [15:0]         blend_index;
   logic                s3_result;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_data_ff, out_data_in;
   logic                out_we_ff, out_we_in, out_last_ff, out_last_in;

   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance;

   assign blend_index = cfg.swap_blend ? {s2_shaded_ff, s2_entry_ff.data}
                                       : {s2_entry_ff.data, s2_shaded_ff};

   // texture stage
   always_ff @(posedge clock) begin
      if (advance) begin
         if (head_valid && head_entry.kind == mtss_pkg::KIND_LOAD_TEXEL) begin
            tex_mem[head_addr[TEX_BITS-1:0]] <= head_entry.data;
         end
         s1_texel_ff <= tex_mem[head_addr[TEX_BITS-1:0]];
         s1_entry_ff <= head_entry;
         s1_addr_ff  <= head_addr[15:0];
      end
   end

   // shade stage
   always_ff @(posedge clock) begin
      if (advance) begin
         if (s1_valid_ff && s1_entry_ff.kind == mtss_pkg::KIND_LOAD_SHADE) begin
            shade_mem[s1_addr_ff[7:0]] <= s1_entry_ff.data;
         end
         s2_shaded_ff <= shade_mem[s1_texel_ff];
         s2_clear_ff  <= (s1_texel_ff == mtss_pkg::TRANSPARENT_TEXEL);
         s2_entry_ff  <= s1_entry_ff;
         s2_addr_ff   <= s1_addr_ff;
      end
   end

   // blend stage
   always_ff @(posedge clock) begin
      if (advance) begin
         if (s2_valid_ff && s2_entry_ff.kind == mtss_pkg::KIND_LOAD_BLEND) begin
            blend_mem[s2_addr_ff] <= s2_entry_ff.data;
         end
         s3_blend_ff  <= blend_mem[blend_index];
         s3_shaded_ff <= s2_shaded_ff;
         s3_clear_ff  <= s2_clear_ff;
         s3_entry_ff  <= s2_entry_ff;
      end
   end

   always_comb begin
      s3_result   = s3_valid_ff && (s3_entry_ff.kind == mtss_pkg::KIND_PIXEL ||
                                    s3_entry_ff.kind == mtss_pkg::KIND_EXHAUSTED);
      out_data_in = s3_entry_ff.data;
      out_we_in   = 1'b0;
      out_last_in = 1'b0;
      if (s3_entry_ff.kind == mtss_pkg::KIND_PIXEL) begin
         out_last_in = s3_entry_ff.last;
         if (!s3_clear_ff) begin
            out_we_in   = 1'b1;
            out_data_in = cfg.blend_mode ? s3_blend_ff : s3_shaded_ff;
         end
      end
      out_valid_in = advance ? s3_result : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_we_ff   <= out_we_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff <= head_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_we_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// ----- rtl/core/masked_translucent_span_shader.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// masked_translucent_span_shader: affine texture span shader
// Register file, request front end, entry queue and table pipeline.
// ----------------------------------------------------------------------------
// One request beat is taken every clock while the four-entry queue has room;
// each pixel beat is offered as one response beat once it has passed the
// queue, texture, shade and blend stages and the result register, one pixel
// per clock sustained while responses are accepted. A stalled response holds
// the whole back end, and the queue fills after four more entries are pushed.
// Load beats write their store in order with pixel beats, so a pixel always
// sees every load sent before it. The stores have no reset.
// ----------------------------------------------------------------------------
module masked_translucent_span_shader #(
   parameter int TEXTURE_ADDR_BITS = 16,
   parameter int SPAN_COUNT_BITS   = 12
) (
   input  wire          clock,
   input  wire          reset,
   // tuser: operation[2:0]
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [2:0]   req_tuser,
   // tdata: table_address[15:0], byte_value[23:16], u_start[55:24],
   //        v_start[87:56], u_increment[119:88], v_increment[151:120],
   //        span_length[163:152], zero fill [167:164]
   input  wire  [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // tdata: pixel_value[7:0]
   output logic [7:0]   rsp_tdata,
   // tuser: write_enable[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [3:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int QADDR_BITS = (TEXTURE_ADDR_BITS > 16) ? TEXTURE_ADDR_BITS : 16;

   mtss_pkg::cfg_type   cfg_ff, cfg_in;
   logic                csr_write;
   logic                q_full, push, pop, head_valid;
   mtss_pkg::entry_type push_entry, head_entry;
   logic [QADDR_BITS-1:0] push_addr, head_addr;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      case (mtss_pkg::csr_index_type'(csr_paddr[3:2]))
         mtss_pkg::CSR_U_SHIFT: begin
            csr_prdata = 32'(cfg_ff.u_shift);
            if (csr_write) cfg_in.u_shift = csr_pwdata[4:0];
         end
         mtss_pkg::CSR_V_BITS: begin
            csr_prdata = 32'(cfg_ff.v_bits);
            if (csr_write) cfg_in.v_bits = csr_pwdata[4:0];
         end
         mtss_pkg::CSR_BLEND_MODE: begin
            csr_prdata = 32'(cfg_ff.blend_mode);
            if (csr_write) cfg_in.blend_mode = csr_pwdata[0];
         end
         mtss_pkg::CSR_SWAP_BLEND: begin
            csr_prdata = 32'(cfg_ff.swap_blend);
            if (csr_write) cfg_in.swap_blend = csr_pwdata[0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.u_shift    <= mtss_pkg::U_SHIFT_RESET;
         cfg_ff.v_bits     <= mtss_pkg::V_BITS_RESET;
         cfg_ff.blend_mode <= 1'b0;
         cfg_ff.swap_blend <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtss_front #(
      .TEX_BITS   (TEXTURE_ADDR_BITS),
      .SPAN_BITS  (SPAN_COUNT_BITS),
      .QADDR_BITS (QADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry),
      .push_addr  (push_addr)
   );

   mtss_queue #(
      .QADDR_BITS (QADDR_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_addr  (push_addr),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_addr  (head_addr)
   );

   mtss_back #(
      .TEX_BITS   (TEXTURE_ADDR_BITS),
      .QADDR_BITS (QADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_addr  (head_addr),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- rtl/core/mtss_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtss_checker: port-level checks of the span shader
// Watches the response channel and the register port over time.
// ----------------------------------------------------------------------------
module mtss_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata,
   input wire        rsp_tuser,
   input wire        rsp_tlast,
   input wire        csr_psel,
   input wire        csr_penable,
   input wire        csr_pwrite,
   input wire [3:0]  csr_paddr,
   input wire [31:0] csr_pwdata,
   input wire [31:0] csr_prdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response beat shown right after reset");

   a_csr_narrow: assert property (@(posedge clock) disable iff (reset)
      csr_prdata[31:5] == 27'd0)
      else $error("register read shows bits beyond the field");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite &&
       csr_paddr == {mtss_pkg::CSR_BLEND_MODE, 2'b00})
         ##1 (csr_paddr == {mtss_pkg::CSR_BLEND_MODE, 2'b00})
         |-> csr_prdata[0] == $past(csr_pwdata[0]))
      else $error("blend mode readback differs from the written value");

endmodule

bind masked_translucent_span_shader mtss_checker u_mtss_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .rsp_tlast   (rsp_tlast),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);
`default_nettype wire
